// File: hw/rtl/polygon_centroid_bbox_defines.svh
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: assertion macros
// Shared assertion helpers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CENTROID_BBOX_DEFINES_SVH
`define POLYGON_CENTROID_BBOX_DEFINES_SVH

// Assert that a property holds at every rising edge out of reset.
`define PCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Assert that a condition never holds at a rising edge out of reset.
`define PCB_ASSERT_NEVER(lbl, cond, msg) \
  `PCB_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: shared package
// Field widths, datapath operation codes and controller interface types.
// ----------------------------------------------------------------------------
package pcb_pkg;

  // Coordinate and accumulator widths.
  localparam int LON_W     = 26;
  localparam int LAT_W     = 25;
  localparam int AREA_W    = 40;
  localparam int MOM_W     = 60;
  localparam int TWICE_W   = 38;
  localparam int DEN_W     = AREA_W + 1;
  localparam int CEN_W     = MOM_W + 2;
  localparam int DIV_CNT_W = $clog2(MOM_W);
  localparam int TALLY_W   = 2;

  // The vertex count saturates at three.
  localparam logic [TALLY_W-1:0] TALLY_FULL = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_REL,
    OP_MUL,
    OP_CROSS,
    OP_MLO,
    OP_MHI,
    OP_MACC,
    OP_PREP,
    OP_DIV,
    OP_FIX,
    OP_FIN
  } pcb_op_e;

  typedef struct packed {
    logic    capture;
    pcb_op_e op;
  } pcb_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic degen;
    logic div_done;
  } pcb_sts_t;

endpackage

// File: hw/rtl/polygon_centroid_bbox.sv
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: top level
// Present one vertex per item on vertex_lon_i / vertex_lat_i with start high;
// the item is taken at a rising edge where start is high and busy is low.
// Set last_vertex_i on the final vertex of a ring. The first vertex of a ring
// sets the origin and starts the bounding box; every later vertex runs the
// per-vertex step sequence (clamp, two multiplies, cross term, two moment
// half-products, accumulate) before the next vertex is accepted. After the last
// vertex the centroid is found by the 60-step restoring divider; a ring of
// fewer than three vertices or of zero area skips the divider and takes the
// midpoint of its bounding box as the centroid. The result is shown
// for exactly one cycle with done_o high; the receiver cannot hold it off, and
// a new vertex may be accepted in that same cycle. Reset clears the controller
// and the vertex count, so the next item starts a new ring.
// ----------------------------------------------------------------------------
module polygon_centroid_bbox #(
  parameter int REL_BITS = 18
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pcb_pkg::LON_W-1:0]   vertex_lon_i,
  input  logic signed [pcb_pkg::LAT_W-1:0]   vertex_lat_i,
  input  logic                               last_vertex_i,
  output logic                               done_o,
  output logic signed [pcb_pkg::LON_W-1:0]   centroid_lon_o,
  output logic signed [pcb_pkg::LAT_W-1:0]   centroid_lat_o,
  output logic                               from_bbox_center_o,
  output logic signed [pcb_pkg::LAT_W-1:0]   min_lat_o,
  output logic signed [pcb_pkg::LAT_W-1:0]   max_lat_o,
  output logic signed [pcb_pkg::LON_W-1:0]   min_lon_o,
  output logic signed [pcb_pkg::LON_W-1:0]   max_lon_o,
  output logic        [pcb_pkg::TWICE_W-1:0] twice_area_o,
  output logic                               extent_overflow_o
);
  import pcb_pkg::*;

  pcb_cmd_t cmd;
  pcb_sts_t sts;

  // Controller sequences the datapath steps.
  pcb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Datapath holds the ring state and the result registers.
  pcb_datapath #(
    .REL_BITS (REL_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .vertex_lon_i       (vertex_lon_i),
    .vertex_lat_i       (vertex_lat_i),
    .last_vertex_i      (last_vertex_i),
    .done_o             (done_o),
    .centroid_lon_o     (centroid_lon_o),
    .centroid_lat_o     (centroid_lat_o),
    .from_bbox_center_o (from_bbox_center_o),
    .min_lat_o          (min_lat_o),
    .max_lat_o          (max_lat_o),
    .min_lon_o          (min_lon_o),
    .max_lon_o          (max_lon_o),
    .twice_area_o       (twice_area_o),
    .extent_overflow_o  (extent_overflow_o)
  );

endmodule

// File: hw/rtl/pcb_divider.sv
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: moment divider
// Restoring divider, one quotient bit per cycle, with an x and a y lane that
// share the divisor and the step counter.
// ----------------------------------------------------------------------------
`include "polygon_centroid_bbox_defines.svh"

module pcb_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcb_pkg::MOM_W-1:0] num_x_i,
  input  logic [pcb_pkg::MOM_W-1:0] num_y_i,
  input  logic [pcb_pkg::DEN_W-1:0] den_i,
  output logic [pcb_pkg::MOM_W-1:0] quo_x_o,
  output logic [pcb_pkg::MOM_W-1:0] quo_y_o,
  output logic                      done_o
);
  import pcb_pkg::*;

  logic                 running_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W-1:0]     rem_x_q, rem_y_q;
  logic [MOM_W-1:0]     num_x_q, num_y_q;

  logic [DEN_W:0]   trial_x, trial_y, diff_x, diff_y;
  logic             ge_x, ge_y;
  logic [DEN_W-1:0] rem_x_d, rem_y_d;
  logic             last_step;

  // Shift the next dividend bit into each partial remainder and try the divisor.
  assign trial_x = {rem_x_q, num_x_q[MOM_W-1]};
  assign trial_y = {rem_y_q, num_y_q[MOM_W-1]};
  assign diff_x  = trial_x - {1'b0, den_q};
  assign diff_y  = trial_y - {1'b0, den_q};
  assign ge_x    = (trial_x >= {1'b0, den_q});
  assign ge_y    = (trial_y >= {1'b0, den_q});
  assign rem_x_d = ge_x ? diff_x[DEN_W-1:0] : trial_x[DEN_W-1:0];
  assign rem_y_d = ge_y ? diff_y[DEN_W-1:0] : trial_y[DEN_W-1:0];

  assign last_step = (cnt_q == DIV_CNT_W'(MOM_W - 1));

  // Run control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q <= running_q && last_step;
      if (start_i) begin
        running_q <= 1'b1;
        cnt_q     <= '0;
      end else if (running_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          running_q <= 1'b0;
        end
      end
    end
  end

  // Dividend registers fill with quotient bits from the bottom as they shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q   <= den_i;
      num_x_q <= num_x_i;
      num_y_q <= num_y_i;
      rem_x_q <= '0;
      rem_y_q <= '0;
    end else if (running_q) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      num_x_q <= {num_x_q[MOM_W-2:0], ge_x};
      num_y_q <= {num_y_q[MOM_W-2:0], ge_y};
    end
  end

  assign quo_x_o = num_x_q;
  assign quo_y_o = num_y_q;
  assign done_o  = done_q;

  `PCB_ASSERT_NEVER(a_start_busy, start_i && running_q, "divider started while running")
  `PCB_ASSERT(a_done_run, done_q |-> $past(running_q), "divider done without a run")

endmodule

// File: hw/rtl/pcb_datapath.sv
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: datapath
// Relative coordinates, shoelace and moment accumulation, bounding box,
// centroid division and result registers, stepped by controller operations.
// ----------------------------------------------------------------------------
`include "polygon_centroid_bbox_defines.svh"

module pcb_datapath #(
  parameter int REL_BITS = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcb_pkg::pcb_cmd_t                 cmd_i,
  output pcb_pkg::pcb_sts_t                 sts_o,
  input  logic signed [pcb_pkg::LON_W-1:0]  vertex_lon_i,
  input  logic signed [pcb_pkg::LAT_W-1:0]  vertex_lat_i,
  input  logic                              last_vertex_i,
  output logic                              done_o,
  output logic signed [pcb_pkg::LON_W-1:0]  centroid_lon_o,
  output logic signed [pcb_pkg::LAT_W-1:0]  centroid_lat_o,
  output logic                              from_bbox_center_o,
  output logic signed [pcb_pkg::LAT_W-1:0]  min_lat_o,
  output logic signed [pcb_pkg::LAT_W-1:0]  max_lat_o,
  output logic signed [pcb_pkg::LON_W-1:0]  min_lon_o,
  output logic signed [pcb_pkg::LON_W-1:0]  max_lon_o,
  output logic        [pcb_pkg::TWICE_W-1:0] twice_area_o,
  output logic                              extent_overflow_o
);
  import pcb_pkg::*;

  // Cross product split point and product widths.
  localparam int SPLIT = REL_BITS + 1;
  localparam int CW    = 2 * REL_BITS + 1;
  localparam int PW    = 2 * REL_BITS + 3;

  // Signed range of a relative coordinate.
  localparam logic signed [LON_W:0] DX_MAX = (LON_W+1)'(2**(REL_BITS-1) - 1);
  localparam logic signed [LON_W:0] DX_MIN = (LON_W+1)'(-(2**(REL_BITS-1)));
  localparam logic signed [LAT_W:0] DY_MAX = (LAT_W+1)'(2**(REL_BITS-1) - 1);
  localparam logic signed [LAT_W:0] DY_MIN = (LAT_W+1)'(-(2**(REL_BITS-1)));

  // Output field ranges for the centre.
  localparam logic signed [CEN_W-1:0] LON_HI = CEN_W'(2**(LON_W-1) - 1);
  localparam logic signed [CEN_W-1:0] LON_LO = CEN_W'(-(2**(LON_W-1)));
  localparam logic signed [CEN_W-1:0] LAT_HI = CEN_W'(2**(LAT_W-1) - 1);
  localparam logic signed [CEN_W-1:0] LAT_LO = CEN_W'(-(2**(LAT_W-1)));

  // Captured item.
  logic signed [LON_W-1:0] in_lon_q;
  logic signed [LAT_W-1:0] in_lat_q;
  logic                    last_q;

  // Ring state.
  logic signed [LON_W-1:0]    origin_lon_q, box_min_lon_q, box_max_lon_q;
  logic signed [LAT_W-1:0]    origin_lat_q, box_min_lat_q, box_max_lat_q;
  logic signed [REL_BITS-1:0] prev_x_q, prev_y_q, rel_x_q, rel_y_q;
  logic signed [AREA_W-1:0]   area_q;
  logic        [MOM_W-1:0]    mom_x_q, mom_y_q;
  logic        [TALLY_W-1:0]  tally_q;
  logic                       clamp_q;

  // Per-vertex pipeline registers.
  logic signed [2*REL_BITS-1:0] p1_q, p2_q;
  logic signed [REL_BITS:0]     sx_q, sy_q;
  logic signed [CW-1:0]         cross_q;
  logic signed [PW-1:0]         prod_x_q, prod_y_q;

  // Ring-end registers.
  logic                    degen_q, neg_x_q, neg_y_q;
  logic [DEN_W-1:0]        den_mag_q;
  logic [MOM_W-1:0]        num_x_q, num_y_q;
  logic [TWICE_W-1:0]      twice_pre_q;
  logic signed [CEN_W-1:0] cx_q, cy_q;

  // Result registers.
  logic                    done_q;
  logic signed [LON_W-1:0] centroid_lon_q, min_lon_q, max_lon_q;
  logic signed [LAT_W-1:0] centroid_lat_q, min_lat_q, max_lat_q;
  logic                    from_bbox_q, overflow_q;
  logic [TWICE_W-1:0]      twice_area_q;

  logic                      first;
  logic signed [LON_W:0]     dx;
  logic signed [LAT_W:0]     dy;
  logic signed [REL_BITS-1:0] rel_x_d, rel_y_d;
  logic                      clamp_d;
  logic signed [2*REL_BITS-1:0] p1_d, p2_d;
  logic signed [REL_BITS:0]  sx_d, sy_d;
  logic signed [CW-1:0]      cross_d;
  logic signed [SPLIT:0]     cross_lo;
  logic signed [REL_BITS-1:0] cross_hi;
  logic signed [PW-1:0]      lo_prod_x, lo_prod_y;
  logic signed [CW-1:0]      hi_prod_x, hi_prod_y;
  logic signed [AREA_W+1:0]  den3;
  logic [AREA_W+1:0]         den3_mag;
  logic [AREA_W-1:0]         area_mag;
  logic [TWICE_W-1:0]        twice_d;
  logic                      degen_d;
  logic [MOM_W-1:0]          num_x_d, num_y_d;
  logic [MOM_W-1:0]          quo_x, quo_y;
  logic                      div_done;
  logic signed [CEN_W-1:0]   qx, qy, ox, oy, mid_x, mid_y, cx_d, cy_d;
  logic signed [LON_W-1:0]   cen_lon_d;
  logic signed [LAT_W-1:0]   cen_lat_d;

  assign first = (tally_q == '0);

  // Offset from the origin, saturated to the relative range.
  assign dx = (LON_W+1)'(in_lon_q) - (LON_W+1)'(origin_lon_q);
  assign dy = (LAT_W+1)'(in_lat_q) - (LAT_W+1)'(origin_lat_q);
  assign rel_x_d = (dx > DX_MAX) ? REL_BITS'(DX_MAX) :
                   (dx < DX_MIN) ? REL_BITS'(DX_MIN) : dx[REL_BITS-1:0];
  assign rel_y_d = (dy > DY_MAX) ? REL_BITS'(DY_MAX) :
                   (dy < DY_MIN) ? REL_BITS'(DY_MIN) : dy[REL_BITS-1:0];
  assign clamp_d = (dx > DX_MAX) || (dx < DX_MIN) || (dy > DY_MAX) || (dy < DY_MIN);

  // Shoelace terms of the edge from the previous point to this one.
  assign p1_d    = prev_x_q * rel_y_q;
  assign p2_d    = rel_x_q * prev_y_q;
  assign sx_d    = prev_x_q + rel_x_q;
  assign sy_d    = prev_y_q + rel_y_q;
  assign cross_d = p1_q - p2_q;

  // Moment products are taken in two halves of the cross term.
  assign cross_lo  = $signed({1'b0, cross_q[SPLIT-1:0]});
  assign cross_hi  = cross_q[CW-1:SPLIT];
  assign lo_prod_x = sx_q * cross_lo;
  assign lo_prod_y = sy_q * cross_lo;
  assign hi_prod_x = sx_q * cross_hi;
  assign hi_prod_y = sy_q * cross_hi;

  // Ring end: divisor magnitude, moment magnitudes, area magnitude.
  assign den3     = (AREA_W+2)'(area_q) + ((AREA_W+2)'(area_q) <<< 1);
  assign den3_mag = den3[AREA_W+1] ? (~den3 + 1'b1) : den3;
  assign num_x_d  = mom_x_q[MOM_W-1] ? (~mom_x_q + 1'b1) : mom_x_q;
  assign num_y_d  = mom_y_q[MOM_W-1] ? (~mom_y_q + 1'b1) : mom_y_q;
  assign area_mag = area_q[AREA_W-1] ? (~area_q + 1'b1) : area_q;
  assign twice_d  = (area_mag[AREA_W-1:TWICE_W] != '0) ? '1 : area_mag[TWICE_W-1:0];
  assign degen_d  = (tally_q != TALLY_FULL) || (area_q == '0);

  // Centre before saturation: signed quotient plus origin, or box midpoint.
  assign qx    = $signed({2'b00, quo_x});
  assign qy    = $signed({2'b00, quo_y});
  assign ox    = CEN_W'(origin_lon_q);
  assign oy    = CEN_W'(origin_lat_q);
  assign mid_x = (CEN_W'(box_min_lon_q) + CEN_W'(box_max_lon_q)) >>> 1;
  assign mid_y = (CEN_W'(box_min_lat_q) + CEN_W'(box_max_lat_q)) >>> 1;
  assign cx_d  = degen_q ? mid_x : (neg_x_q ? (ox - qx) : (ox + qx));
  assign cy_d  = degen_q ? mid_y : (neg_y_q ? (oy - qy) : (oy + qy));

  // Saturate the centre to the field widths.
  assign cen_lon_d = (cx_q > LON_HI) ? LON_W'(LON_HI) :
                     (cx_q < LON_LO) ? LON_W'(LON_LO) : cx_q[LON_W-1:0];
  assign cen_lat_d = (cy_q > LAT_HI) ? LAT_W'(LAT_HI) :
                     (cy_q < LAT_LO) ? LAT_W'(LAT_LO) : cy_q[LAT_W-1:0];

  pcb_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_DIV),
    .num_x_i (num_x_q),
    .num_y_i (num_y_q),
    .den_i   (den_mag_q),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .done_o  (div_done)
  );

  // Vertex count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_FIN);
      if (cmd_i.op == OP_REL && tally_q != TALLY_FULL) begin
        tally_q <= tally_q + 1'b1;
      end else if (cmd_i.op == OP_FIN) begin
        tally_q <= '0;
      end
    end
  end

  // Working registers, stepped by the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_lon_q <= vertex_lon_i;
      in_lat_q <= vertex_lat_i;
      last_q   <= last_vertex_i;
    end
    case (cmd_i.op)
      OP_REL: begin
        if (first) begin
          origin_lon_q  <= in_lon_q;
          origin_lat_q  <= in_lat_q;
          box_min_lon_q <= in_lon_q;
          box_max_lon_q <= in_lon_q;
          box_min_lat_q <= in_lat_q;
          box_max_lat_q <= in_lat_q;
          prev_x_q      <= '0;
          prev_y_q      <= '0;
          area_q        <= '0;
          mom_x_q       <= '0;
          mom_y_q       <= '0;
          clamp_q       <= 1'b0;
        end else begin
          rel_x_q <= rel_x_d;
          rel_y_q <= rel_y_d;
          clamp_q <= clamp_q | clamp_d;
          if (in_lon_q < box_min_lon_q) box_min_lon_q <= in_lon_q;
          if (in_lon_q > box_max_lon_q) box_max_lon_q <= in_lon_q;
          if (in_lat_q < box_min_lat_q) box_min_lat_q <= in_lat_q;
          if (in_lat_q > box_max_lat_q) box_max_lat_q <= in_lat_q;
        end
      end
      OP_MUL: begin
        p1_q     <= p1_d;
        p2_q     <= p2_d;
        sx_q     <= sx_d;
        sy_q     <= sy_d;
        prev_x_q <= rel_x_q;
        prev_y_q <= rel_y_q;
      end
      OP_CROSS: begin
        cross_q <= cross_d;
      end
      OP_MLO: begin
        area_q   <= area_q + AREA_W'(cross_q);
        prod_x_q <= lo_prod_x;
        prod_y_q <= lo_prod_y;
      end
      OP_MHI: begin
        mom_x_q  <= mom_x_q + MOM_W'(prod_x_q);
        mom_y_q  <= mom_y_q + MOM_W'(prod_y_q);
        prod_x_q <= PW'(hi_prod_x);
        prod_y_q <= PW'(hi_prod_y);
      end
      OP_MACC: begin
        mom_x_q <= mom_x_q + (MOM_W'(prod_x_q) << SPLIT);
        mom_y_q <= mom_y_q + (MOM_W'(prod_y_q) << SPLIT);
      end
      OP_PREP: begin
        degen_q     <= degen_d;
        den_mag_q   <= den3_mag[DEN_W-1:0];
        num_x_q     <= num_x_d;
        num_y_q     <= num_y_d;
        neg_x_q     <= mom_x_q[MOM_W-1] ^ den3[AREA_W+1];
        neg_y_q     <= mom_y_q[MOM_W-1] ^ den3[AREA_W+1];
        twice_pre_q <= twice_d;
      end
      OP_FIX: begin
        cx_q <= cx_d;
        cy_q <= cy_d;
      end
      OP_FIN: begin
        centroid_lon_q <= cen_lon_d;
        centroid_lat_q <= cen_lat_d;
        from_bbox_q    <= degen_q;
        min_lat_q      <= box_min_lat_q;
        max_lat_q      <= box_max_lat_q;
        min_lon_q      <= box_min_lon_q;
        max_lon_q      <= box_max_lon_q;
        twice_area_q   <= twice_pre_q;
        overflow_q     <= clamp_q;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.first    = first;
  assign sts_o.last     = last_q;
  assign sts_o.degen    = degen_q;
  assign sts_o.div_done = div_done;

  assign done_o             = done_q;
  assign centroid_lon_o     = centroid_lon_q;
  assign centroid_lat_o     = centroid_lat_q;
  assign from_bbox_center_o = from_bbox_q;
  assign min_lat_o          = min_lat_q;
  assign max_lat_o          = max_lat_q;
  assign min_lon_o          = min_lon_q;
  assign max_lon_o          = max_lon_q;
  assign twice_area_o       = twice_area_q;
  assign extent_overflow_o  = overflow_q;

  `PCB_ASSERT(a_done_single, done_q |=> !done_q, "result strobe held for more than one cycle")
  `PCB_ASSERT(a_done_clear, done_q |-> (tally_q == '0), "vertex count not cleared with result")

endmodule

// File: hw/rtl/pcb_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon centroid and bounding box: controller
// Sequences the per-vertex steps and the ring-end division and output.
// ----------------------------------------------------------------------------
module pcb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output pcb_pkg::pcb_cmd_t cmd_o,
  input  pcb_pkg::pcb_sts_t sts_i
);
  import pcb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REL,
    ST_MUL,
    ST_CROSS,
    ST_MLO,
    ST_MHI,
    ST_MACC,
    ST_PREP,
    ST_LAUNCH,
    ST_WAIT,
    ST_FIX,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_REL;
      ST_REL: begin
        if (!sts_i.first) state_d = ST_MUL;
        else if (sts_i.last) state_d = ST_PREP;
        else state_d = ST_IDLE;
      end
      ST_MUL:    state_d = ST_CROSS;
      ST_CROSS:  state_d = ST_MLO;
      ST_MLO:    state_d = ST_MHI;
      ST_MHI:    state_d = ST_MACC;
      ST_MACC:   state_d = sts_i.last ? ST_PREP : ST_IDLE;
      ST_PREP:   state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = sts_i.degen ? ST_FIX : ST_WAIT;
      ST_WAIT:   if (sts_i.div_done) state_d = ST_FIX;
      ST_FIX:    state_d = ST_FIN;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  // Datapath operation for the current state.
  always_comb begin
    cmd_o.capture = start && !busy_q;
    case (state_q)
      ST_REL:    cmd_o.op = OP_REL;
      ST_MUL:    cmd_o.op = OP_MUL;
      ST_CROSS:  cmd_o.op = OP_CROSS;
      ST_MLO:    cmd_o.op = OP_MLO;
      ST_MHI:    cmd_o.op = OP_MHI;
      ST_MACC:   cmd_o.op = OP_MACC;
      ST_PREP:   cmd_o.op = OP_PREP;
      ST_LAUNCH: cmd_o.op = sts_i.degen ? OP_NONE : OP_DIV;
      ST_FIX:    cmd_o.op = OP_FIX;
      ST_FIN:    cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign busy = busy_q;

endmodule
